// ===== rtl/core/frgcd_pkg.sv =====
// Shared constants and types for the fraction reducer core.
// No dependencies; imported by the core and its checker.
package frgcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int K_W        = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_GCD,
        ST_SHIFT,
        ST_DIVN,
        ST_DIVD
    } t_state;

endpackage

// ===== rtl/core/fraction_reducer_gcd_core.sv =====
// Fraction reducer core: binary GCD, then two restoring divisions on one subtractor.
// Depends on frgcd_pkg. One word is taken at a time while busy is high.
// A zero denominator goes through ST_ZERO straight to its flagged result. Otherwise the core
// runs the GCD loop, shifts the common factor of two back in, then does both divisions;
// the GCD loop and the divisions share the one subtractor.
// A new word is taken only when idle. Reset is synchronous and active low; it returns to idle.
module fraction_reducer_gcd_core
    import frgcd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_numerator_in,
    input  logic        [DATA_WIDTH-1:0] i_denominator_in,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_numerator_out,
    output logic        [DATA_WIDTH-1:0] o_denominator_out,
    output logic                         o_zero_denominator
);

    t_state                  r_state, n_state;
    logic [DATA_WIDTH-1:0]   r_a, n_a, r_b, n_b, r_g, n_g;
    logic [DATA_WIDTH-1:0]   r_q, n_q, r_r, n_r;
    logic [DATA_WIDTH-1:0]   r_mag, n_mag, r_den, n_den, r_qn, n_qn;
    logic [K_W-1:0]          r_k, n_k, r_cnt, n_cnt;
    logic                    r_neg, n_neg;
    logic                    r_valid, n_valid;
    logic [DATA_WIDTH-1:0]   r_num_out, n_num_out, r_den_out, n_den_out;
    logic                    r_zero, n_zero;

    logic [DATA_WIDTH:0]     sub_x, sub_y, div_t, div_rem;
    logic [DATA_WIDTH+1:0]   diff;
    logic                    borrow;
    logic [DATA_WIDTH-1:0]   div_q;

    assign div_t   = {r_r, r_q[DATA_WIDTH-1]};
    assign diff    = {1'b0, sub_x} - {1'b0, sub_y};
    assign borrow  = diff[DATA_WIDTH+1];
    assign div_rem = borrow ? div_t : diff[DATA_WIDTH:0];
    assign div_q   = {r_q[DATA_WIDTH-2:0], ~borrow};

    always_comb begin
        if (r_state == ST_GCD) begin
            sub_x = {1'b0, r_a};
            sub_y = {1'b0, r_b};
        end else begin
            sub_x = div_t;
            sub_y = {1'b0, r_g};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_a       <= n_a;
        r_b       <= n_b;
        r_g       <= n_g;
        r_q       <= n_q;
        r_r       <= n_r;
        r_mag     <= n_mag;
        r_den     <= n_den;
        r_qn      <= n_qn;
        r_k       <= n_k;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_num_out <= n_num_out;
        r_den_out <= n_den_out;
        r_zero    <= n_zero;
    end

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_g       = r_g;
        n_q       = r_q;
        n_r       = r_r;
        n_mag     = r_mag;
        n_den     = r_den;
        n_qn      = r_qn;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_valid   = 1'b0;
        n_num_out = r_num_out;
        n_den_out = r_den_out;
        n_zero    = r_zero;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_neg = i_numerator_in[DATA_WIDTH-1];
                    n_mag = i_numerator_in[DATA_WIDTH-1] ?
                            (DATA_WIDTH'(0) - DATA_WIDTH'(i_numerator_in)) :
                            DATA_WIDTH'(i_numerator_in);
                    n_den = i_denominator_in;
                    n_a   = i_denominator_in;
                    n_b   = n_mag;
                    n_k   = '0;
                    n_state = (i_denominator_in == '0) ? ST_ZERO : ST_GCD;
                end
            end
            ST_ZERO: begin
                n_num_out = '0;
                n_den_out = '0;
                n_zero    = 1'b1;
                n_valid   = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_GCD: begin
                priority if (r_a == '0) begin
                    n_g     = r_b;
                    n_state = ST_SHIFT;
                end else if (r_b == '0) begin
                    n_g     = r_a;
                    n_state = ST_SHIFT;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + K_W'(1);
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (!borrow) begin
                    n_a = diff[DATA_WIDTH-1:0];
                end else begin
                    n_a = r_b;
                    n_b = r_a;
                end
            end
            ST_SHIFT: begin
                if (r_k == '0) begin
                    n_q     = r_mag;
                    n_r     = '0;
                    n_cnt   = K_W'(DATA_WIDTH - 1);
                    n_state = ST_DIVN;
                end else begin
                    n_g = r_g << 1;
                    n_k = r_k - K_W'(1);
                end
            end
            ST_DIVN: begin
                n_q   = div_q;
                n_r   = div_rem[DATA_WIDTH-1:0];
                n_cnt = r_cnt - K_W'(1);
                if (r_cnt == '0) begin
                    n_qn    = div_q;
                    n_q     = r_den;
                    n_r     = '0;
                    n_cnt   = K_W'(DATA_WIDTH - 1);
                    n_state = ST_DIVD;
                end
            end
            ST_DIVD: begin
                n_q   = div_q;
                n_r   = div_rem[DATA_WIDTH-1:0];
                n_cnt = r_cnt - K_W'(1);
                if (r_cnt == '0) begin
                    n_num_out = r_neg ? (DATA_WIDTH'(0) - r_qn) : r_qn;
                    n_den_out = div_q;
                    n_zero    = 1'b0;
                    n_valid   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_valid            = r_valid;
    assign o_numerator_out    = $signed(r_num_out);
    assign o_denominator_out  = r_den_out;
    assign o_zero_denominator = r_zero;

endmodule

// ===== rtl/core/frgcd_checker.sv =====
// Port-level checker for the fraction reducer core, with its bind statement.
// Depends on frgcd_pkg and fraction_reducer_gcd_core.
module frgcd_checker
    import frgcd_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic signed [DATA_WIDTH-1:0] o_numerator_out,
    input logic        [DATA_WIDTH-1:0] o_denominator_out,
    input logic                         o_zero_denominator
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted word");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_zero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_denominator |-> o_numerator_out == '0 && o_denominator_out == '0)
        else $error("zero denominator result is not all zero");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_denominator |-> o_denominator_out != '0)
        else $error("reduced denominator is zero without the error flag");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

endmodule

bind fraction_reducer_gcd_core frgcd_checker u_frgcd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_numerator_out    (o_numerator_out),
    .o_denominator_out  (o_denominator_out),
    .o_zero_denominator (o_zero_denominator)
);

// ===== sim/tb_fraction_reducer_gcd_core.sv =====
// Self-checking testbench for fraction_reducer_gcd_core: directed corner words, then random
// fractions, many with shared factors, checked against a behavioral Euclid-based reducer.
// Depends on frgcd_pkg and the core RTL only.
module tb_fraction_reducer_gcd_core;
    import frgcd_pkg::*;

    localparam int W = DATA_WIDTH;

    typedef struct packed {
        logic signed [W-1:0] num;
        logic        [W-1:0] den;
        logic                zero_den;
    } fraction_t;

    class fraction_checker;
        fraction_t expected_fractions[$];
        int        mismatches = 0;

        function automatic fraction_t reduce_fraction(logic signed [W-1:0] num,
                                                      logic [W-1:0] den);
            fraction_t    res;
            logic         neg;
            logic [W-1:0] mag, a, b, r, qn;
            neg = num[W-1];
            mag = num;
            if (neg) mag = -mag;
            res = '0;
            if (den == '0) begin
                res.zero_den = 1'b1;
                return res;
            end
            a = den;
            b = mag;
            while (b != '0) begin
                r = a % b;
                a = b;
                b = r;
            end
            qn = mag / a;
            res.num = neg ? -qn : qn;
            res.den = den / a;
            return res;
        endfunction

        function void note_word(logic signed [W-1:0] num, logic [W-1:0] den);
            expected_fractions.push_back(reduce_fraction(num, den));
        endfunction

        function void check_word(logic signed [W-1:0] num, logic [W-1:0] den, logic zd);
            fraction_t want;
            if (expected_fractions.size() == 0) begin
                $display("%0t: unexpected word num=%0d den=%0d zero_den=%0b",
                         $time, num, den, zd);
                mismatches++;
                return;
            end
            want = expected_fractions.pop_front();
            if (num !== want.num) begin
                $display("%0t: numerator expected %0d got %0d", $time, $signed(want.num), num);
                mismatches++;
            end
            if (den !== want.den) begin
                $display("%0t: denominator expected %0d got %0d", $time, want.den, den);
                mismatches++;
            end
            if (zd !== want.zero_den) begin
                $display("%0t: zero_denominator expected %0b got %0b", $time, want.zero_den, zd);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_fractions.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic signed [W-1:0] i_numerator_in;
    logic        [W-1:0] i_denominator_in;
    logic                o_valid;
    logic signed [W-1:0] o_numerator_out;
    logic        [W-1:0] o_denominator_out;
    logic                o_zero_denominator;

    fraction_checker board = new();

    fraction_reducer_gcd_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_numerator_in     (i_numerator_in),
        .i_denominator_in   (i_denominator_in),
        .o_valid            (o_valid),
        .o_numerator_out    (o_numerator_out),
        .o_denominator_out  (o_denominator_out),
        .o_zero_denominator (o_zero_denominator)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_word(i_numerator_in, i_denominator_in);
            if (o_valid) board.check_word(o_numerator_out, o_denominator_out, o_zero_denominator);
        end
    end

    task automatic send_word(input logic signed [W-1:0] num, input logic [W-1:0] den,
                             input bit quiet);
        i_numerator_in   <= num;
        i_denominator_in <= den;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 140)) @(negedge i_clk);
        end
    endtask

    initial begin
        #12_000_000;
        $display("** fraction_reducer_gcd_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [W-1:0]        g, a, b, lim, den;
        logic signed [W-1:0] num;
        int                  mode;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_numerator_in   = '0;
        i_denominator_in = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(32'sd0, 32'd1, 1'b0);
        send_word(32'sd0, '1, 1'b0);
        send_word(32'sd0, 32'd0, 1'b0);
        send_word(32'sd1, 32'd0, 1'b0);
        send_word(32'sh8000_0000, 32'd0, 1'b0);
        send_word(-32'sd1, 32'd1, 1'b0);
        send_word(32'sd1, '1, 1'b0);
        send_word(-32'sd1, '1, 1'b0);
        send_word(32'sh7FFF_FFFF, '1, 1'b0);
        send_word(32'sh7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_word(32'sh7FFF_FFFF, 32'd1, 1'b0);
        send_word(32'sh8000_0000, 32'h8000_0000, 1'b0);
        send_word(32'sh8000_0000, '1, 1'b0);
        send_word(32'sh8000_0000, 32'd6, 1'b0);
        send_word(32'sh8000_0000, 32'd1, 1'b0);
        send_word(32'sh4000_0000, 32'h8000_0000, 1'b0);
        send_word(32'sd12, 32'd18, 1'b0);
        send_word(-32'sd12, 32'd18, 1'b0);
        send_word(-32'sd18, 32'd12, 1'b0);
        send_word(32'sd1024, 32'd12288, 1'b0);
        send_word(32'sd1836311903, 32'd2971215073, 1'b0);
        send_word(-32'sd1836311903, 32'd2971215073, 1'b0);

        for (int k = 0; k < 550; k++) begin
            mode = $urandom_range(0, 99);
            if (mode < 30) begin
                num = $urandom;
                den = $urandom;
            end else if (mode < 33) begin
                num = $urandom;
                den = '0;
            end else if (mode < 36) begin
                num = '0;
                den = $urandom;
            end else if (mode < 85) begin
                g   = (32'd1 + ($urandom >> $urandom_range(8, 31))) << $urandom_range(0, 7);
                lim = '1 / g;
                a   = $urandom_range(lim, 0);
                b   = $urandom_range(lim, 1);
                num = a * g;
                if ($urandom_range(0, 1)) num = -num;
                den = b * g;
            end else begin
                num = $signed(32'($urandom_range(200, 0))) - 32'sd100;
                den = $urandom_range(100, 0);
            end
            send_word(num, den, k >= 150 && k < 300);
        end
        start <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("** fraction_reducer_gcd_core: PASSED **");
        end else begin
            $display("** fraction_reducer_gcd_core: FAILED **");
        end
        $finish;
    end
endmodule
